### rtl/core/imf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package imf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_WINDOW = 7;
   localparam int DEF_MAX_HEIGHT = 4095;

   localparam int PIX_W        = 8;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam int CFG_SEL_W    = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 12;
   // holds the selector plus one before clamping
   localparam int PAD_W        = 3;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SELECT = 2'd2;

   localparam logic [CFG_WIDTH_W-1:0]  RESET_FRAME_WIDTH   = 11'd640;
   localparam logic [CFG_HEIGHT_W-1:0] RESET_FRAME_HEIGHT  = 12'd480;
   localparam logic [CFG_SEL_W-1:0]    RESET_WINDOW_SELECT = 2'd0;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   typedef struct packed {
      logic capture;
      logic cfg_write;
      logic rd_win;
      logic rd_held;
      logic shift;
      logic latch;
      logic store;
      logic med_start;
      logic emit;
   } imf_cmd_type;

   typedef struct packed {
      logic pixel;
      logic emit;
      logic interior;
      logic med_done;
      logic out_free;
   } imf_status_type;

endpackage

`default_nettype wire

### rtl/core/imf_select.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_select #(
   parameter int WIN_SIDE = 7
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   input  wire logic [WIN_SIDE*WIN_SIDE-1:0][imf_pkg::PIX_W-1:0] samples,
   input  wire logic [WIN_SIDE*WIN_SIDE-1:0]             mask,
   input  wire logic [$clog2(WIN_SIDE*WIN_SIDE+1)-1:0]   rank,
   output logic                                          done,
   output logic [imf_pkg::PIX_W-1:0]                     median
);
   import imf_pkg::*;

   localparam int CNT_W = $clog2(WIN_SIDE*WIN_SIDE+1);
   localparam int RC_W  = $clog2(WIN_SIDE+1);
   localparam logic [PIX_W-1:0] TOP_BIT = {1'b1, {(PIX_W-1){1'b0}}};

   logic                             busy_ff;
   logic                             phase_ff;
   logic                             done_ff;
   logic [PIX_W-1:0]                 bit_ff;
   logic [PIX_W-1:0]                 hmask_ff;
   logic [PIX_W-1:0]                 prefix_ff;
   logic [CNT_W-1:0]                 rank_ff;
   logic [WIN_SIDE-1:0][RC_W-1:0]    row_cnt_ff;
   logic [WIN_SIDE-1:0][RC_W-1:0]    row_cnt_in;
   logic [CNT_W-1:0]                 total;

   // count candidates with the current bit clear, one count per row, all rows at once
   always_comb begin
      for (int k = 0; k < WIN_SIDE; k++) begin
         row_cnt_in[k] = '0;
         for (int j = 0; j < WIN_SIDE; j++) begin
            if (mask[k*WIN_SIDE+j] &&
                (((samples[k*WIN_SIDE+j] ^ prefix_ff) & hmask_ff) == '0) &&
                ((samples[k*WIN_SIDE+j] & bit_ff) == '0)) begin
               row_cnt_in[k] = row_cnt_in[k] + RC_W'(1);
            end
         end
      end
   end

   always_comb begin
      total = '0;
      for (int k = 0; k < WIN_SIDE; k++) begin
         total = total + CNT_W'(row_cnt_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
         end else if (busy_ff) begin
            phase_ff <= ~phase_ff;
            if (phase_ff && bit_ff[0]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         bit_ff    <= TOP_BIT;
         hmask_ff  <= '0;
         prefix_ff <= '0;
         rank_ff   <= rank;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            row_cnt_ff <= row_cnt_in;
         end else begin
            if (rank_ff >= total) begin
               prefix_ff <= prefix_ff | bit_ff;
               rank_ff   <= rank_ff - total;
            end
            hmask_ff <= hmask_ff | bit_ff;
            bit_ff   <= bit_ff >> 1;
         end
      end
   end

   assign done   = done_ff;
   assign median = prefix_ff;

endmodule

`default_nettype wire

### rtl/core/imf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    csr_valid,
   input  wire imf_pkg::imf_status_type status,
   output imf_pkg::imf_cmd_type         cmd,
   output logic                         req_stall,
   output logic                         csr_ready
);
   import imf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD_WIN,
      ST_SHIFT,
      ST_RD_HELD,
      ST_LATCH,
      ST_MEDIAN,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      pixel_ff;
   logic      emit_ff;
   logic      idle;
   logic      accept;

   assign idle      = (state_ff == ST_IDLE);
   assign csr_ready = idle;
   assign req_stall = !idle || csr_valid;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      cmd.cfg_write = csr_valid && idle;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               if (status.pixel) begin
                  state_in = ST_RD_WIN;
               end else if (status.emit) begin
                  state_in = ST_RD_HELD;
               end
            end
         end
         ST_RD_WIN: begin
            cmd.rd_win = 1'b1;
            state_in   = ST_SHIFT;
         end
         ST_SHIFT: begin
            cmd.shift   = 1'b1;
            cmd.rd_held = 1'b1;
            state_in    = ST_LATCH;
         end
         ST_RD_HELD: begin
            cmd.rd_held = 1'b1;
            state_in    = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.latch = 1'b1;
            cmd.store = pixel_ff;
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (status.interior) begin
               cmd.med_start = 1'b1;
               state_in      = ST_MEDIAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_MEDIAN: begin
            if (status.med_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pixel_ff <= 1'b0;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            pixel_ff <= status.pixel;
            emit_ff  <= status.emit;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/imf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_dpath #(
   parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = imf_pkg::DEF_MAX_WINDOW,
   parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire imf_pkg::imf_cmd_type                cmd,
   output imf_pkg::imf_status_type                  status,
   input  wire logic                                req_kind,
   input  wire logic [imf_pkg::PIX_W-1:0]           req_red_in,
   input  wire logic [imf_pkg::PIX_W-1:0]           req_green_in,
   input  wire logic [imf_pkg::PIX_W-1:0]           req_blue_in,
   input  wire logic [imf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [imf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_valid,
   output logic [imf_pkg::PIX_W-1:0]                rsp_red_out,
   output logic [imf_pkg::PIX_W-1:0]                rsp_green_out,
   output logic [imf_pkg::PIX_W-1:0]                rsp_blue_out,
   output logic                                     rsp_frame_end,
   output logic                                     rsp_size_error
);
   import imf_pkg::*;

   localparam int MAX_PAD    = (MAX_WINDOW - 1) / 2;
   localparam int WIN_SIDE   = 2 * MAX_PAD + 1;
   localparam int WIN_N      = WIN_SIDE * WIN_SIDE;
   localparam int STORE_ROWS = WIN_SIDE - 1;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WDT_W      = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
   localparam int SLOT_W     = $clog2(STORE_ROWS);
   localparam int PEND_W     = $clog2(MAX_PAD * (MAX_WIDTH + 1) + 1);
   localparam int CNT_W      = $clog2(WIN_N + 1);
   localparam int WORD_W     = 3 * PIX_W;

   logic [CFG_WIDTH_W-1:0]  cfg_width_ff;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff;
   logic [CFG_SEL_W-1:0]    cfg_sel_ff;
   logic                    cfg_hit;

   logic [WDT_W-1:0]  w_eff;
   logic [ROW_W-1:0]  h_eff;
   logic [PAD_W-1:0]  pad_raw;
   logic [PAD_W-1:0]  pad;
   logic [PAD_W:0]    side;
   logic              err;
   logic [PEND_W-1:0] lag;
   logic [CNT_W-1:0]  rank;
   logic [WIN_N-1:0]  win_mask;

   logic [COL_W-1:0]  in_col_ff;
   logic [ROW_W-1:0]  in_row_ff;
   logic [SLOT_W-1:0] in_slot_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [SLOT_W-1:0] out_slot_ff;
   logic [PEND_W-1:0] pend_ff;
   logic              complete;
   logic              pixel;
   logic              interior;
   logic              last;

   logic [PIX_W-1:0]  item_red_ff;
   logic [PIX_W-1:0]  item_green_ff;
   logic [PIX_W-1:0]  item_blue_ff;

   logic [WORD_W-1:0] row_mem [STORE_ROWS][MAX_WIDTH];
   logic [WORD_W-1:0] bank_rd_ff [STORE_ROWS];
   logic [COL_W-1:0]  rd_addr;
   logic [WORD_W-1:0] held_ff;

   logic [WIN_N-1:0][PIX_W-1:0] win_ff;
   logic [PIX_W-1:0]            new_col [WIN_SIDE];

   logic              med_done;
   logic [PIX_W-1:0]  med_value;
   logic              rsp_valid_ff;
   logic              out_free;

   // clamp the registers to what the datapath supports
   always_comb begin
      if (cfg_width_ff == '0) begin
         w_eff = WDT_W'(1);
      end else if (32'(cfg_width_ff) > MAX_WIDTH) begin
         w_eff = WDT_W'(MAX_WIDTH);
      end else begin
         w_eff = WDT_W'(cfg_width_ff);
      end
      if (cfg_height_ff == '0) begin
         h_eff = ROW_W'(1);
      end else if (32'(cfg_height_ff) > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(cfg_height_ff);
      end
      pad_raw = PAD_W'(cfg_sel_ff) + PAD_W'(1);
      pad     = (32'(pad_raw) > MAX_PAD) ? PAD_W'(MAX_PAD) : pad_raw;
      side    = {pad, 1'b1};
      err     = (32'(w_eff) < 32'(side)) || (32'(h_eff) < 32'(side));
      lag     = PEND_W'(32'(pad) * 32'(w_eff) + 32'(pad));
      rank    = CNT_W'((32'(side) * 32'(side)) >> 1);
      for (int k = 0; k < WIN_SIDE; k++) begin
         for (int j = 0; j < WIN_SIDE; j++) begin
            win_mask[k*WIN_SIDE+j] = (k >= WIN_SIDE - 32'(side)) &&
                                     (j >= WIN_SIDE - 32'(side));
         end
      end
   end

   assign complete = (in_row_ff >= h_eff);
   assign pixel    = (req_kind == KIND_PIXEL) && !complete;
   assign interior = !err &&
                     (32'(out_row_ff) >= 32'(pad)) &&
                     (32'(out_row_ff) + 32'(pad) < 32'(h_eff)) &&
                     (32'(out_col_ff) >= 32'(pad)) &&
                     (32'(out_col_ff) + 32'(pad) < 32'(w_eff));
   assign last     = (32'(out_row_ff) + 1 == 32'(h_eff)) &&
                     (32'(out_col_ff) + 1 == 32'(w_eff));
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status          = '0;
      status.pixel    = pixel;
      status.emit     = pixel ? (pend_ff >= lag) : (complete && (pend_ff != '0));
      status.interior = interior;
      status.med_done = med_done;
      status.out_free = out_free;
   end

   always_comb begin
      cfg_hit = 1'b0;
      unique case (csr_index)
         REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_WINDOW_SELECT: cfg_hit = 1'b1;
         default: cfg_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RESET_FRAME_WIDTH;
         cfg_height_ff <= RESET_FRAME_HEIGHT;
         cfg_sel_ff    <= RESET_WINDOW_SELECT;
      end else if (cmd.cfg_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:   cfg_width_ff  <= csr_wdata[CFG_WIDTH_W-1:0];
            REG_FRAME_HEIGHT:  cfg_height_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
            REG_WINDOW_SELECT: cfg_sel_ff    <= csr_wdata[CFG_SEL_W-1:0];
            default: ;
         endcase
      end
   end

   // frame position counters; the slots track row modulo the store depth
   always_ff @(posedge clock) begin
      if (reset || (cmd.cfg_write && cfg_hit)) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         pend_ff     <= '0;
      end else if (cmd.store) begin
         pend_ff <= pend_ff + PEND_W'(1);
         if (32'(in_col_ff) + 1 >= 32'(w_eff)) begin
            in_col_ff  <= '0;
            in_row_ff  <= in_row_ff + ROW_W'(1);
            in_slot_ff <= (32'(in_slot_ff) + 1 == STORE_ROWS) ?
                          '0 : in_slot_ff + SLOT_W'(1);
         end else begin
            in_col_ff <= in_col_ff + COL_W'(1);
         end
      end else if (cmd.emit) begin
         if (last) begin
            in_col_ff   <= '0;
            in_row_ff   <= '0;
            in_slot_ff  <= '0;
            out_col_ff  <= '0;
            out_row_ff  <= '0;
            out_slot_ff <= '0;
            pend_ff     <= '0;
         end else begin
            pend_ff <= pend_ff - PEND_W'(1);
            if (32'(out_col_ff) + 1 >= 32'(w_eff)) begin
               out_col_ff  <= '0;
               out_row_ff  <= out_row_ff + ROW_W'(1);
               out_slot_ff <= (32'(out_slot_ff) + 1 == STORE_ROWS) ?
                              '0 : out_slot_ff + SLOT_W'(1);
            end else begin
               out_col_ff <= out_col_ff + COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_red_ff   <= req_red_in;
         item_green_ff <= req_green_in;
         item_blue_ff  <= req_blue_in;
      end
   end

   // row store: one bank per stored row, all banks read at one column
   assign rd_addr = cmd.rd_held ? out_col_ff : in_col_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         row_mem[in_slot_ff][in_col_ff] <= {item_red_ff, item_green_ff, item_blue_ff};
      end
      if (cmd.rd_win || cmd.rd_held) begin
         for (int b = 0; b < STORE_ROWS; b++) begin
            bank_rd_ff[b] <= row_mem[b][rd_addr];
         end
      end
      if (cmd.latch) begin
         held_ff <= bank_rd_ff[out_slot_ff];
      end
   end

   // new window column: oldest stored row on top, current pixel at the bottom
   always_comb begin
      int s;
      for (int k = 0; k < STORE_ROWS; k++) begin
         s = 32'(in_slot_ff) + k;
         if (s >= STORE_ROWS) begin
            s = s - STORE_ROWS;
         end
         new_col[k] = bank_rd_ff[SLOT_W'(s)][WORD_W-1 -: PIX_W];
      end
      new_col[WIN_SIDE-1] = item_red_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.cfg_write && cfg_hit)) begin
         win_ff <= '0;
      end else if (cmd.shift) begin
         for (int k = 0; k < WIN_SIDE; k++) begin
            for (int j = 0; j < WIN_SIDE - 1; j++) begin
               win_ff[k*WIN_SIDE+j] <= win_ff[k*WIN_SIDE+j+1];
            end
            win_ff[k*WIN_SIDE+WIN_SIDE-1] <= new_col[k];
         end
      end
   end

   imf_select #(
      .WIN_SIDE (WIN_SIDE)
   ) u_select (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.med_start),
      .samples (win_ff),
      .mask    (win_mask),
      .rank    (rank),
      .done    (med_done),
      .median  (med_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         if (interior) begin
            rsp_red_out   <= med_value;
            rsp_green_out <= med_value;
            rsp_blue_out  <= med_value;
         end else begin
            rsp_red_out   <= held_ff[WORD_W-1 -: PIX_W];
            rsp_green_out <= held_ff[2*PIX_W-1 -: PIX_W];
            rsp_blue_out  <= held_ff[PIX_W-1:0];
         end
         rsp_frame_end  <= last;
         rsp_size_error <= err;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/image_median_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Square median filter (3x3, 5x5 or 7x7) over an RGB pixel stream in raster
// order. Each interior pixel is replaced by the median of the red channel
// over the window centred on it, copied to all three channels; pixels within
// half a window of the frame edge pass through unchanged. Results lag the
// input by pad*width+pad pixels (pad is half the window side), so after the
// last pixel of a frame send drain transactions (kind 1) to flush the held
// pixels; rsp_frame_end marks the last result. A frame smaller than the
// window passes through unchanged with rsp_size_error set on every result.
// Any register write aborts the frame in progress; write only while idle.
// One transaction is worked at a time. A pixel reads the window column,
// shifts it in while reading the held pixel, then latches that and stores
// itself; a drain only reads and latches. A median waits on the radix select
// unit, which for each result bit counts per window row, then sums the rows.
// The result register lets the next transaction enter while a result waits.
// The row store is a plain memory with no reset; no clearing pass is needed.

module image_median_filter_core #(
   parameter int MAX_WIDTH  = imf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_WINDOW = imf_pkg::DEF_MAX_WINDOW,
   parameter int MAX_HEIGHT = imf_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // pixel / drain transactions
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_kind,
   input  wire logic [imf_pkg::PIX_W-1:0]       req_red_in,
   input  wire logic [imf_pkg::PIX_W-1:0]       req_green_in,
   input  wire logic [imf_pkg::PIX_W-1:0]       req_blue_in,
   // result transactions
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [imf_pkg::PIX_W-1:0]            rsp_red_out,
   output logic [imf_pkg::PIX_W-1:0]            rsp_green_out,
   output logic [imf_pkg::PIX_W-1:0]            rsp_blue_out,
   output logic                                 rsp_frame_end,
   output logic                                 rsp_size_error,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [imf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [imf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import imf_pkg::*;

   imf_cmd_type    cmd;
   imf_status_type status;

   // sequence each transaction: read window column, shift, read held
   // pixel, store, optional median, then hand the result to the output
   imf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .csr_ready (csr_ready)
   );

   // counters, row store, window and output register
   imf_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_kind       (req_kind),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_size_error (rsp_size_error)
   );

endmodule

`default_nettype wire

### rtl/core/imf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module imf_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          req_kind,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [imf_pkg::PIX_W-1:0]     rsp_red_out,
   input wire logic [imf_pkg::PIX_W-1:0]     rsp_green_out,
   input wire logic [imf_pkg::PIX_W-1:0]     rsp_blue_out,
   input wire logic                          rsp_frame_end,
   input wire logic                          rsp_size_error,
   input wire logic                          csr_valid,
   input wire logic                          csr_ready
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red_out) &&
      $stable(rsp_green_out) && $stable(rsp_blue_out) &&
      $stable(rsp_frame_end) && $stable(rsp_size_error))
      else $error("result changed while stalled");

   // a pixel transaction always occupies the block; drains may be dropped at once
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_kind == imf_pkg::KIND_PIXEL) |=> req_stall)
      else $error("input taken while a transaction is in work");

   // a new result only comes out of a busy block
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a transaction in work");

   // idle and no register write pending: input must be open
   a_idle_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready && !csr_valid |-> !req_stall)
      else $error("idle block stalls input");

endmodule

bind image_median_filter_core imf_checker u_imf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_kind       (req_kind),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_red_out    (rsp_red_out),
   .rsp_green_out  (rsp_green_out),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_frame_end  (rsp_frame_end),
   .rsp_size_error (rsp_size_error),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);

`default_nettype wire
